FILE: design/spq_pkg.sv
// Shared types and codes for the stable priority packet queue.
`default_nettype none
package spq_pkg;

    // Default number of cells in the queue.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths of a stored descriptor and of the result.
    localparam int HANDLE_W = 16;
    localparam int SIZE_W   = 11;
    localparam int PRIO_W   = 8;
    localparam int OCC_W    = 5;

    // Request kinds carried on the input tuser bit.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes carried on the output tuser bits.
    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // One stored descriptor.
    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry push_entry;
    } t_cell_ctl;

endpackage : spq_pkg
`default_nettype wire

FILE: design/spq_cell.sv
// One cell of the sorted shift chain: holds a descriptor and moves it left or right.
`default_nettype none
module spq_cell
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_valid,
    input  wire logic      i_left_ge,
    input  wire t_entry    i_left_data,
    input  wire t_entry    i_right_data,
    output logic           o_ge,
    output t_entry         o_data
);

    t_entry r_data;
    t_entry n_data;

    // The cell stays in front of a new entry when it holds an equal or higher priority.
    assign o_ge   = i_valid && (r_data.prio >= i_ctl.push_entry.prio);
    assign o_data = r_data;

    // A push takes the new entry at the first cell that yields, and shifts the rest right.
    // A pop shifts every cell one step toward the head.
    always_comb begin
        n_data = r_data;
        if (i_ctl.pop) begin
            n_data = i_right_data;
        end else if (i_ctl.push && !o_ge) begin
            if (i_left_ge) begin
                n_data = i_ctl.push_entry;
            end else begin
                n_data = i_left_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule : spq_cell
`default_nettype wire

FILE: design/stable_priority_packet_queue.sv
// The result of a request is registered and appears on the output in the cycle after it is accepted.
// One push or pop request per cycle while the output is not stalled; every cell compares its priority
// against the new one in parallel and the whole chain shifts in that same cycle.
// Reset clears the entry count and the output valid; stored descriptors are not
// cleared, since only cells below the count are ever read.
`default_nettype none
module stable_priority_packet_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: packet_handle[15:0], packet_size[26:16], priority_req[34:27], zero fill
    input  wire logic [39:0] i_s_axis_tdata,
    // tuser: mode
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: out_handle[15:0], out_size[26:16], occupancy[31:27]
    output logic [31:0]      o_m_axis_tdata,
    // tuser: status
    output logic [1:0]       o_m_axis_tuser
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic               w_accept;
    logic               w_is_pop;
    logic               w_empty;
    logic               w_full;
    t_entry             w_req_entry;
    t_cell_ctl          w_ctl;
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_ge;
    t_entry             w_data [QUEUE_DEPTH];

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    t_status            r_status;
    t_status            n_status;
    logic [HANDLE_W-1:0] r_handle;
    logic [HANDLE_W-1:0] n_handle;
    logic [SIZE_W-1:0]  r_size;
    logic [SIZE_W-1:0]  n_size;
    logic [OCC_W-1:0]   r_occ;
    logic [OCC_W-1:0]   n_occ;
    logic [CNT_W+OCC_W-1:0] w_count_ext;

    // Request decode.
    assign o_s_axis_tready    = !r_out_valid || i_m_axis_tready;
    assign w_accept           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_pop           = (i_s_axis_tuser == MODE_POP);
    assign w_req_entry.handle = i_s_axis_tdata[15:0];
    assign w_req_entry.size   = i_s_axis_tdata[26:16];
    assign w_req_entry.prio   = i_s_axis_tdata[34:27];
    assign w_empty            = (r_count == '0);
    assign w_full             = (r_count == CNT_W'(QUEUE_DEPTH));

    assign w_ctl.push       = w_accept && !w_is_pop && !w_full;
    assign w_ctl.pop        = w_accept && w_is_pop && !w_empty;
    assign w_ctl.push_entry = w_req_entry;

    // Chain of cells, head at index zero.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_right;
        logic   w_left_ge;
        t_entry w_left;

        assign w_valid[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_head
            assign w_left_ge = 1'b1;
            assign w_left    = w_req_entry;
        end else begin : g_body
            assign w_left_ge = w_ge[g-1];
            assign w_left    = w_data[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (w_valid[g]),
            .i_left_ge    (w_left_ge),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .o_ge         (w_ge[g]),
            .o_data       (w_data[g])
        );
    end

    // Entry count follows each push or pop that changes the chain.
    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Occupancy is the new count reduced to the output field width.
    assign w_count_ext = {{OCC_W{1'b0}}, n_count};

    // Result register, loaded for each accepted request.
    always_comb begin
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_status    = r_status;
        n_handle    = r_handle;
        n_size      = r_size;
        n_occ       = r_occ;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_handle    = '0;
            n_size      = '0;
            n_occ       = w_count_ext[OCC_W-1:0];
            if (w_is_pop) begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_POPPED;
                    n_handle = w_data[0].handle;
                    n_size   = w_data[0].size;
                end
            end else begin
                n_status = w_full ? ST_FULL : ST_PUSHED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_handle <= n_handle;
        r_size   <= n_size;
        r_occ    <= n_occ;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_occ, r_size, r_handle};
    assign o_m_axis_tuser  = r_status;

endmodule : stable_priority_packet_queue
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the stable priority packet queue.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 200;

    // One result as seen on the output stream.
    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
        logic [OCC_W-1:0]    occ;
    } pkt_result_t;

    // One row of the directed request table.
    typedef struct {
        logic                mode;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
        logic [PRIO_W-1:0]   prio;
        bit                  fixed;
        pkt_result_t         res;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tuser = MODE_PUSH;
    logic [39:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [31:0] o_m_axis_tdata;
    wire  [1:0]  o_m_axis_tuser;

    // Typed expectation that travels with the request currently offered.
    bit          res_fixed = 1'b0;
    pkt_result_t res_fixed_val = '0;

    // Predictor state: descriptors in service order, head first.
    logic [HANDLE_W-1:0] queue_handle [DEPTH];
    logic [SIZE_W-1:0]   queue_size   [DEPTH];
    logic [PRIO_W-1:0]   queue_prio   [DEPTH];
    int                  queue_count = 0;

    pkt_result_t pending_results [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count = 0;
    int          hold_asked = 0;
    int          cycle_count = 0;

    stable_priority_packet_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one request to the predicted queue and returns its result.
    function automatic pkt_result_t predict_queue_step(
        input logic                mode,
        input logic [HANDLE_W-1:0] handle,
        input logic [SIZE_W-1:0]   size,
        input logic [PRIO_W-1:0]   prio
    );
        pkt_result_t r;
        int          pos;
        r = '0;
        if (mode == MODE_POP) begin
            if (queue_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status = ST_POPPED;
                r.handle = queue_handle[0];
                r.size   = queue_size[0];
                for (int i = 1; i < queue_count; i++) begin
                    queue_handle[i-1] = queue_handle[i];
                    queue_size[i-1]   = queue_size[i];
                    queue_prio[i-1]   = queue_prio[i];
                end
                queue_count--;
            end
        end else if (queue_count >= DEPTH) begin
            r.status = ST_FULL;
        end else begin
            // A new entry goes behind every entry of higher or equal priority.
            pos = 0;
            while (pos < queue_count && queue_prio[pos] >= prio)
                pos++;
            for (int i = queue_count; i > pos; i--) begin
                queue_handle[i] = queue_handle[i-1];
                queue_size[i]   = queue_size[i-1];
                queue_prio[i]   = queue_prio[i-1];
            end
            queue_handle[pos] = handle;
            queue_size[pos]   = size;
            queue_prio[pos]   = prio;
            queue_count++;
            r.status = ST_PUSHED;
        end
        r.occ = queue_count[OCC_W-1:0];
        return r;
    endfunction

    // Offers one request and returns once it has been taken.
    task automatic offer_request(
        input logic                mode,
        input logic [HANDLE_W-1:0] handle,
        input logic [SIZE_W-1:0]   size,
        input logic [PRIO_W-1:0]   prio,
        input bit                  fixed,
        input pkt_result_t         fixed_res
    );
        s_tvalid      <= 1'b1;
        s_tuser       <= mode;
        s_tdata       <= {5'b0, prio, size, handle};
        res_fixed     <= fixed;
        res_fixed_val <= fixed_res;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Ends a burst with a random gap, or with none so bursts also run back to back.
    task automatic burst_gap(inout int burst_left);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    function automatic void add_row(
        input logic                mode,
        input logic [HANDLE_W-1:0] handle,
        input logic [SIZE_W-1:0]   size,
        input logic [PRIO_W-1:0]   prio,
        input bit                  fixed,
        input t_status             status,
        input logic [HANDLE_W-1:0] out_handle,
        input logic [SIZE_W-1:0]   out_size,
        input logic [OCC_W-1:0]    occ
    );
        stim_row_t row;
        row.mode       = mode;
        row.handle     = handle;
        row.size       = size;
        row.prio       = prio;
        row.fixed      = fixed;
        row.res.status = status;
        row.res.handle = out_handle;
        row.res.size   = out_size;
        row.res.occ    = occ;
        directed_rows.push_back(row);
    endfunction

    // Request side: the directed table, then random phases of pushes and pops.
    initial begin
        logic [PRIO_W-1:0] fill_prio [16];
        int                burst_left;
        int                phase_left;
        int                push_pct;
        int                hold_at;
        logic              mode;
        logic [PRIO_W-1:0] prio;

        fill_prio = '{8'd7, 8'd7, 8'd200, 8'd0, 8'd255, 8'd7, 8'd200, 8'd1,
                      8'd0, 8'd255, 8'd128, 8'd7, 8'd64, 8'd200, 8'd3, 8'd0};

        // Empty pop, extremes, equal priority keeping arrival order.
        add_row(MODE_POP,  16'h0000, 11'h000, 8'h00, 1, ST_EMPTY,  16'h0000, 11'h000, 5'd0);
        add_row(MODE_PUSH, 16'hFFFF, 11'h7FF, 8'hFF, 1, ST_PUSHED, 16'h0000, 11'h000, 5'd1);
        add_row(MODE_PUSH, 16'h0000, 11'h000, 8'h00, 1, ST_PUSHED, 16'h0000, 11'h000, 5'd2);
        add_row(MODE_PUSH, 16'h1234, 11'h001, 8'hFF, 1, ST_PUSHED, 16'h0000, 11'h000, 5'd3);
        add_row(MODE_POP,  16'hFFFF, 11'h7FF, 8'hFF, 1, ST_POPPED, 16'hFFFF, 11'h7FF, 5'd2);
        add_row(MODE_POP,  16'h0000, 11'h000, 8'h00, 1, ST_POPPED, 16'h1234, 11'h001, 5'd1);
        add_row(MODE_POP,  16'h5555, 11'h2AA, 8'hAA, 1, ST_POPPED, 16'h0000, 11'h000, 5'd0);
        add_row(MODE_POP,  16'hAAAA, 11'h555, 8'h55, 1, ST_EMPTY,  16'h0000, 11'h000, 5'd0);
        // Fill to capacity with mixed and repeated priorities.
        for (int i = 0; i < 16; i++)
            add_row(MODE_PUSH, 16'hA000 + 16'(i * 4099), 11'(i * 131), fill_prio[i], 0,
                    ST_PUSHED, 16'h0000, 11'h000, 5'd0);
        // Push onto a full queue is dropped; then a pop from the full queue.
        add_row(MODE_PUSH, 16'hBEEF, 11'h3FF, 8'hFF, 1, ST_FULL, 16'h0000, 11'h000, 5'd16);
        add_row(MODE_POP,  16'h0000, 11'h000, 8'h00, 0, ST_POPPED, 16'h0000, 11'h000, 5'd0);

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = 0;
        foreach (directed_rows[i]) begin
            burst_gap(burst_left);
            offer_request(directed_rows[i].mode, directed_rows[i].handle,
                          directed_rows[i].size, directed_rows[i].prio,
                          directed_rows[i].fixed, directed_rows[i].res);
        end

        // Random phases lean toward filling, draining, or a balanced mix.
        phase_left = 0;
        push_pct   = 50;
        hold_at    = $urandom_range(100, 250);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
            // Narrow priorities give many ties; extremes and full range as well.
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: prio = PRIO_W'($urandom_range(0, 3));
                5:             prio = 8'h00;
                6:             prio = 8'hFF;
                default:       prio = PRIO_W'($urandom_range(0, 255));
            endcase
            burst_gap(burst_left);
            if (n == hold_at)
                hold_asked++;
            offer_request(mode, HANDLE_W'($urandom_range(0, 65535)),
                          SIZE_W'($urandom_range(0, 2047)), prio, 0, '0);
        end
        s_tvalid  <= 1'b0;
        res_fixed <= 1'b0;

        // Let the checker record the last request before waiting on its result.
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("stable_priority_packet_queue verification clean");
        else
            $display("stable_priority_packet_queue verification failed");
        $finish;
    end

    // Result side: switches among stall patterns, and holds off for a long
    // stretch when asked so that the queue backs up into its input.
    initial begin
        int hold_done;
        int pattern;
        int pattern_left;
        int tick;
        hold_done    = 0;
        pattern      = 0;
        pattern_left = 0;
        tick         = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_done) begin
                hold_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (pattern_left == 0) begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 64);
            end
            pattern_left--;
            tick++;
            case (pattern)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (tick % 3 == 0);
            endcase
        end
    end

    // Predicts each taken request and checks each taken result in order.
    always @(posedge i_clk) begin
        pkt_result_t predicted;
        pkt_result_t seen;
        pkt_result_t wanted;
        if (rst_n) begin
            if (s_tvalid && o_s_axis_tready) begin
                predicted = predict_queue_step(s_tuser, s_tdata[15:0], s_tdata[26:16],
                                               s_tdata[34:27]);
                pending_results.push_back(res_fixed ? res_fixed_val : predicted);
            end
            if (o_m_axis_tvalid && m_tready) begin
                seen.status = t_status'(o_m_axis_tuser);
                seen.handle = o_m_axis_tdata[15:0];
                seen.size   = o_m_axis_tdata[26:16];
                seen.occ    = o_m_axis_tdata[31:27];
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"%0t: result with none expected:",
                                  " status %0d handle %h size %h occ %0d"},
                                 $time, seen.status, seen.handle, seen.size, seen.occ);
                end else begin
                    wanted = pending_results.pop_front();
                    if (wanted.status !== seen.status || wanted.handle !== seen.handle ||
                        wanted.size !== seen.size || wanted.occ !== seen.occ) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"%0t: mismatch expected status %0d handle %h size %h occ %0d",
                                      ", actual status %0d handle %h size %h occ %0d"},
                                     $time, wanted.status, wanted.handle, wanted.size,
                                     wanted.occ, seen.status, seen.handle, seen.size, seen.occ);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("stable_priority_packet_queue verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_packet_queue.sv
tb/sv/tb.sv
